// ===== sv/key_press_gesture_detector_unit_macros.svh =====
// Assertion helpers for the top-level RTL; they expect clk and rst_n in scope.
`ifndef KEY_PRESS_GESTURE_DETECTOR_UNIT_MACROS_SVH
`define KEY_PRESS_GESTURE_DETECTOR_UNIT_MACROS_SVH

// Same-cycle implication.
`define KPGD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define KPGD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/kpgd_pkg.sv =====
package kpgd_pkg;

    localparam int KPGD_KEY_COUNT = 2;
    localparam int KPGD_CROWN_KEY = 0;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 31;

    localparam logic [CFG_ADDR_W-1:0] CFG_DOUBLE_WINDOW  = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_UNLOCK_HOLD    = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_RELEASE_SETTLE = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_HOLD_CROWN     = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_HOLD_OTHER     = 3'd4;

    localparam logic [CFG_DATA_W-1:0] RST_DOUBLE_WINDOW  = 31'd300;
    localparam logic [CFG_DATA_W-1:0] RST_UNLOCK_HOLD    = 31'd2000;
    localparam logic [CFG_DATA_W-1:0] RST_RELEASE_SETTLE = 31'd50;
    localparam logic [CFG_DATA_W-1:0] RST_HOLD_CROWN     = 31'd800;
    localparam logic [CFG_DATA_W-1:0] RST_HOLD_OTHER     = 31'd800;

    typedef enum logic [2:0] {
        OP_TICK    = 3'd0,
        OP_EDGE    = 3'd1,
        OP_RECOVER = 3'd2,
        OP_CANCEL  = 3'd3,
        OP_LOCK    = 3'd4
    } op_t;

    typedef enum logic [2:0] {
        KIND_NONE   = 3'd0,
        KIND_SINGLE = 3'd1,
        KIND_DOUBLE = 3'd2,
        KIND_HOLD   = 3'd3,
        KIND_UNLOCK = 3'd4
    } kind_t;

    typedef struct packed {
        logic [CFG_DATA_W-1:0] double_window;
        logic [CFG_DATA_W-1:0] unlock_hold;
        logic [CFG_DATA_W-1:0] release_settle;
        logic [CFG_DATA_W-1:0] hold_crown;
        logic [CFG_DATA_W-1:0] hold_other;
    } cfg_t;

    // Signals raised by one item: count (0 means one empty result) and up to three slots.
    typedef struct packed {
        logic [1:0]      n;
        logic [2:0]      key;
        logic [2:0][2:0] kind;
    } sig_grp_t;

    // Per-key deadline description: remaining = period - (now - start), when active.
    typedef struct packed {
        logic                  act;
        logic [CFG_DATA_W-1:0] period;
        logic [31:0]           start;
    } dl_t;

endpackage

// ===== sv/kpgd_core.sv =====
module kpgd_core
    import kpgd_pkg::*;
#(
    parameter int KEY_COUNT = KPGD_KEY_COUNT,
    parameter int CROWN_KEY = KPGD_CROWN_KEY
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        upd,
    input  cfg_t        cfg,
    input  logic [2:0]  op,
    input  logic        key_index,
    input  logic        is_pressed,
    input  logic [31:0] now_tick,
    input  logic        lock_on,
    output sig_grp_t    grp,
    output dl_t         dl [KEY_COUNT],
    output logic [31:0] now_out
);

    logic [KEY_COUNT-1:0] down_reg, held_reg, pend_reg, sec_reg, await_reg, stab_reg;
    logic [KEY_COUNT-1:0] down_next, held_next, pend_next, sec_next, await_next, stab_next;
    logic [31:0] press_reg [KEY_COUNT];
    logic [31:0] rel_reg [KEY_COUNT];
    logic [31:0] stabt_reg [KEY_COUNT];
    logic [31:0] press_next [KEY_COUNT];
    logic [31:0] rel_next [KEY_COUNT];
    logic [31:0] stabt_next [KEY_COUNT];
    logic [31:0] last_reg, last_next;
    logic        tv_reg, tv_next;
    logic        wl_reg, wl_next;

    sig_grp_t grp_reg, grp_next;
    dl_t      dl_reg [KEY_COUNT];
    dl_t      dl_next [KEY_COUNT];
    logic [31:0] now_reg;

    logic [KEY_COUNT-1:0] hold_ok, dbl_ok, settle_ok;
    logic [31:0] diff_last;
    logic        stale;
    logic        in_rng;

    // Per-key expiry compares against the state as it stood before this word.
    always_comb
    begin
        logic [31:0] d_press, d_rel, d_stab;
        logic [CFG_DATA_W-1:0] hold_t;
        for (int j = 0; j < KEY_COUNT; j++)
        begin
            d_press = now_tick - press_reg[j];
            d_rel   = now_tick - rel_reg[j];
            d_stab  = now_tick - stabt_reg[j];
            if (j == CROWN_KEY)
                hold_t = wl_reg ? cfg.unlock_hold : cfg.hold_crown;
            else
                hold_t = cfg.hold_other;
            hold_ok[j]   = d_press >= {1'b0, hold_t};
            dbl_ok[j]    = d_rel >= {1'b0, cfg.double_window};
            settle_ok[j] = !d_stab[31] && (d_stab >= {1'b0, cfg.release_settle});
        end
    end

    assign diff_last = now_tick - last_reg;
    assign stale     = tv_reg && diff_last[31];
    assign in_rng    = (KEY_COUNT > 1) || !key_index;

    always_comb
    begin
        logic [1:0] cnt;
        logic [1:0] limit;
        logic       cancel;
        logic       do_adv;
        logic [CFG_DATA_W-1:0] hold_n;

        down_next  = down_reg;
        held_next  = held_reg;
        pend_next  = pend_reg;
        sec_next   = sec_reg;
        await_next = await_reg;
        stab_next  = stab_reg;
        press_next = press_reg;
        rel_next   = rel_reg;
        stabt_next = stabt_reg;
        last_next  = last_reg;
        tv_next    = tv_reg;
        wl_next    = wl_reg;
        grp_next   = '0;
        cnt        = 2'd0;
        cancel     = 1'b0;
        do_adv     = 1'b0;
        limit      = 2'd3;

        case (op_t'(op))
            OP_TICK:
            begin
                do_adv = 1'b1;
                limit  = 2'd3;
            end
            OP_EDGE:
            begin
                do_adv = in_rng;
                limit  = 2'd2;   // one slot stays free for the edge's own signal
            end
            OP_RECOVER:
            begin
                if (in_rng)
                begin
                    for (int j = 0; j < KEY_COUNT; j++)
                    begin
                        if (j == int'(key_index) && await_reg[j])
                        begin
                            if (is_pressed)
                                stab_next[j] = 1'b0;
                            else if (!stab_reg[j])
                            begin
                                stab_next[j]  = 1'b1;
                                stabt_next[j] = now_tick;
                            end
                            else if (settle_ok[j])
                            begin
                                down_next[j]  = 1'b0;
                                held_next[j]  = 1'b0;
                                pend_next[j]  = 1'b0;
                                sec_next[j]   = 1'b0;
                                await_next[j] = 1'b0;
                                stab_next[j]  = 1'b0;
                            end
                        end
                    end
                end
            end
            OP_CANCEL:
            begin
                cancel = 1'b1;
            end
            OP_LOCK:
            begin
                if (wl_reg != lock_on)
                begin
                    cancel  = 1'b1;
                    wl_next = lock_on;
                end
            end
            default:
            begin
            end
        endcase

        if (do_adv)
        begin
            if (stale)
                cancel = 1'b1;
            else
            begin
                last_next = now_tick;
                tv_next   = 1'b1;
                for (int j = 0; j < KEY_COUNT; j++)
                begin
                    if (cnt < limit && !await_reg[j])
                    begin
                        if (down_reg[j] && !held_reg[j] && hold_ok[j])
                        begin
                            held_next[j] = 1'b1;
                            pend_next[j] = 1'b0;
                            sec_next[j]  = 1'b0;
                            grp_next.key[cnt]  = 1'(j);
                            grp_next.kind[cnt] = (wl_reg && j == CROWN_KEY) ? KIND_UNLOCK
                                                                            : KIND_HOLD;
                            cnt = cnt + 2'd1;
                        end
                        else if (pend_reg[j] && dbl_ok[j])
                        begin
                            pend_next[j] = 1'b0;
                            grp_next.key[cnt]  = 1'(j);
                            grp_next.kind[cnt] = KIND_SINGLE;
                            cnt = cnt + 2'd1;
                        end
                    end
                end

                // The edge itself sees the state after the tick part.
                if (op_t'(op) == OP_EDGE)
                begin
                    for (int j = 0; j < KEY_COUNT; j++)
                    begin
                        if (j == int'(key_index))
                        begin
                            if (await_next[j])
                            begin
                                if (!is_pressed)
                                begin
                                    down_next[j]  = 1'b0;
                                    held_next[j]  = 1'b0;
                                    pend_next[j]  = 1'b0;
                                    sec_next[j]   = 1'b0;
                                    await_next[j] = 1'b0;
                                    stab_next[j]  = 1'b0;
                                end
                            end
                            else if (is_pressed != down_next[j])
                            begin
                                down_next[j] = is_pressed;
                                if (is_pressed)
                                begin
                                    sec_next[j]   = pend_next[j];
                                    pend_next[j]  = 1'b0;
                                    held_next[j]  = 1'b0;
                                    press_next[j] = now_tick;
                                end
                                else if (!held_next[j])
                                begin
                                    if (sec_next[j])
                                    begin
                                        sec_next[j] = 1'b0;
                                        grp_next.key[cnt]  = 1'(j);
                                        grp_next.kind[cnt] = KIND_DOUBLE;
                                        cnt = cnt + 2'd1;
                                    end
                                    else
                                    begin
                                        pend_next[j] = 1'b1;
                                        rel_next[j]  = now_tick;
                                    end
                                end
                            end
                        end
                    end
                end
            end
        end

        if (cancel)
        begin
            down_next  = '0;
            held_next  = '0;
            pend_next  = '0;
            sec_next   = '0;
            stab_next  = '0;
            await_next = '1;
        end

        grp_next.n = cnt;

        // Deadline of each key after this word; a settling key counts release_settle in full.
        for (int j = 0; j < KEY_COUNT; j++)
        begin
            if (j == CROWN_KEY)
                hold_n = wl_next ? cfg.unlock_hold : cfg.hold_crown;
            else
                hold_n = cfg.hold_other;
            dl_next[j].act    = 1'b1;
            dl_next[j].period = cfg.release_settle;
            dl_next[j].start  = now_tick;
            if (await_next[j])
            begin
            end
            else if (down_next[j] && !held_next[j])
            begin
                dl_next[j].period = hold_n;
                dl_next[j].start  = press_next[j];
            end
            else if (pend_next[j])
            begin
                dl_next[j].period = cfg.double_window;
                dl_next[j].start  = rel_next[j];
            end
            else
                dl_next[j].act = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            down_reg  <= '0;
            held_reg  <= '0;
            pend_reg  <= '0;
            sec_reg   <= '0;
            await_reg <= '0;
            stab_reg  <= '0;
            last_reg  <= '0;
            tv_reg    <= 1'b0;
            wl_reg    <= 1'b0;
        end
        else if (upd)
        begin
            down_reg  <= down_next;
            held_reg  <= held_next;
            pend_reg  <= pend_next;
            sec_reg   <= sec_next;
            await_reg <= await_next;
            stab_reg  <= stab_next;
            last_reg  <= last_next;
            tv_reg    <= tv_next;
            wl_reg    <= wl_next;
        end
    end

    // Timestamps are only read while their flag is set.
    always_ff @(posedge clk)
    begin
        if (upd)
        begin
            press_reg <= press_next;
            rel_reg   <= rel_next;
            stabt_reg <= stabt_next;
            grp_reg   <= grp_next;
            dl_reg    <= dl_next;
            now_reg   <= now_tick;
        end
    end

    assign grp     = grp_reg;
    assign dl      = dl_reg;
    assign now_out = now_reg;

endmodule

// ===== sv/kpgd_wait.sv =====
module kpgd_wait
    import kpgd_pkg::*;
#(
    parameter int KEY_COUNT = KPGD_KEY_COUNT
)
(
    input  logic        clk,
    input  logic        load,
    input  dl_t         dl [KEY_COUNT],
    input  logic [31:0] now_tick,
    input  sig_grp_t    grp_in,
    output logic [31:0] rem [KEY_COUNT],
    output sig_grp_t    grp_out
);

    logic [31:0] rem_reg [KEY_COUNT];
    logic [31:0] rem_next [KEY_COUNT];
    sig_grp_t    grp_reg;

    always_comb
    begin
        logic [31:0] elapsed;
        logic [31:0] period;
        for (int j = 0; j < KEY_COUNT; j++)
        begin
            elapsed = now_tick - dl[j].start;
            period  = {1'b0, dl[j].period};
            if (!dl[j].act)
                rem_next[j] = '1;
            else if (elapsed >= period)
                rem_next[j] = '0;
            else
                rem_next[j] = period - elapsed;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            rem_reg <= rem_next;
            grp_reg <= grp_in;
        end
    end

    assign rem     = rem_reg;
    assign grp_out = grp_reg;

endmodule

// ===== sv/kpgd_out.sv =====
module kpgd_out
    import kpgd_pkg::*;
#(
    parameter int KEY_COUNT = KPGD_KEY_COUNT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        load,
    input  logic        take,
    input  logic [31:0] rem [KEY_COUNT],
    input  sig_grp_t    grp_in,
    output logic        valid,
    output logic        key,
    output logic [2:0]  kind,
    output logic [31:0] wait_ticks,
    output logic        last
);

    logic        v_reg, v_next;
    logic [1:0]  idx_reg, idx_next;
    sig_grp_t    grp_reg;
    logic [31:0] wait_reg;
    logic [31:0] min_next;

    always_comb
    begin
        min_next = '1;
        for (int j = 0; j < KEY_COUNT; j++)
        begin
            if (rem[j] < min_next)
                min_next = rem[j];
        end
    end

    // An item with no signal still gives one empty word.
    assign last = (grp_reg.n == 2'd0) || (idx_reg == grp_reg.n - 2'd1);

    always_comb
    begin
        v_next   = v_reg;
        idx_next = idx_reg;
        if (load)
        begin
            v_next   = 1'b1;
            idx_next = 2'd0;
        end
        else if (take)
        begin
            if (last)
                v_next = 1'b0;
            else
                idx_next = idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg   <= 1'b0;
            idx_reg <= 2'd0;
        end
        else
        begin
            v_reg   <= v_next;
            idx_reg <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            grp_reg  <= grp_in;
            wait_reg <= min_next;
        end
    end

    assign valid      = v_reg;
    assign key        = grp_reg.key[idx_reg];
    assign kind       = grp_reg.kind[idx_reg];
    assign wait_ticks = wait_reg;

endmodule

// ===== sv/key_press_gesture_detector_unit.sv =====
// A word passes the input, state, remaining-time and output registers before its first result
//   word is valid. Input words enter one per cycle while no stage stalls; an item leaves
//   1 to 3 result words, one per cycle through the single output register as m_tready allows.
// The key state registers take one whole word update per cycle between input and result
//   unless the state stage stalls. Reset (rst_n low, asynchronous) empties the pipeline,
//   clears all key state and loads the register defaults.
module key_press_gesture_detector_unit
    import kpgd_pkg::*;
#(
    parameter int KEY_COUNT = KPGD_KEY_COUNT,
    parameter int CROWN_KEY = KPGD_CROWN_KEY
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [39:0]           s_tdata,   // key_index, is_pressed, now_tick[31:0], lock_on
    input  logic [2:0]            s_tuser,   // operation
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [39:0]           m_tdata,   // signal_key, wait_ticks[31:0]
    output logic [2:0]            m_tuser,   // signal_kind
    output logic                  m_tlast
);

    `include "key_press_gesture_detector_unit_macros.svh"

    cfg_t cfg_reg;

    logic        a_v_reg, b_v_reg, c_v_reg;
    logic        a_v_next, b_v_next, c_v_next;
    logic [2:0]  op_reg;
    logic        key_reg, prs_reg, lock_reg;
    logic [31:0] now_reg;

    logic s_acc, o_free, take;
    logic a_adv, b_adv, c_adv;
    logic a_load, b_load, c_load;

    sig_grp_t    grp_b, grp_c;
    dl_t         dl_b [KEY_COUNT];
    logic [31:0] now_b;
    logic [31:0] rem_c [KEY_COUNT];

    logic        o_key;
    logic [2:0]  o_kind;
    logic [31:0] o_wait;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.double_window  <= RST_DOUBLE_WINDOW;
            cfg_reg.unlock_hold    <= RST_UNLOCK_HOLD;
            cfg_reg.release_settle <= RST_RELEASE_SETTLE;
            cfg_reg.hold_crown     <= RST_HOLD_CROWN;
            cfg_reg.hold_other     <= RST_HOLD_OTHER;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                CFG_DOUBLE_WINDOW:  cfg_reg.double_window  <= cfg_wdata;
                CFG_UNLOCK_HOLD:    cfg_reg.unlock_hold    <= cfg_wdata;
                CFG_RELEASE_SETTLE: cfg_reg.release_settle <= cfg_wdata;
                CFG_HOLD_CROWN:     cfg_reg.hold_crown     <= cfg_wdata;
                CFG_HOLD_OTHER:     cfg_reg.hold_other     <= cfg_wdata;
                default:            ;
            endcase
        end
    end

    // Pipeline: input reg (A) -> state update (B) -> remaining time (C) -> output group.
    assign take   = m_tvalid && m_tready;
    assign o_free = !m_tvalid || (take && m_tlast);
    assign c_adv  = o_free;
    assign b_adv  = !c_v_reg || c_adv;
    assign a_adv  = !b_v_reg || b_adv;
    assign c_load = c_v_reg && c_adv;
    assign b_load = b_v_reg && b_adv;
    assign a_load = a_v_reg && a_adv;

    assign s_tready = !a_v_reg || a_adv;
    assign s_acc    = s_tvalid && s_tready;

    assign a_v_next = s_acc || (a_v_reg && !a_adv);
    assign b_v_next = a_load || (b_v_reg && !b_adv);
    assign c_v_next = b_load || (c_v_reg && !c_adv);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_v_reg <= 1'b0;
            b_v_reg <= 1'b0;
            c_v_reg <= 1'b0;
        end
        else
        begin
            a_v_reg <= a_v_next;
            b_v_reg <= b_v_next;
            c_v_reg <= c_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_acc)
        begin
            op_reg   <= s_tuser;
            key_reg  <= s_tdata[0];
            prs_reg  <= s_tdata[1];
            now_reg  <= s_tdata[33:2];
            lock_reg <= s_tdata[34];
        end
    end

    kpgd_core #(
        .KEY_COUNT (KEY_COUNT),
        .CROWN_KEY (CROWN_KEY)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .upd        (a_load),
        .cfg        (cfg_reg),
        .op         (op_reg),
        .key_index  (key_reg),
        .is_pressed (prs_reg),
        .now_tick   (now_reg),
        .lock_on    (lock_reg),
        .grp        (grp_b),
        .dl         (dl_b),
        .now_out    (now_b)
    );

    kpgd_wait #(
        .KEY_COUNT (KEY_COUNT)
    ) u_wait (
        .clk      (clk),
        .load     (b_load),
        .dl       (dl_b),
        .now_tick (now_b),
        .grp_in   (grp_b),
        .rem      (rem_c),
        .grp_out  (grp_c)
    );

    kpgd_out #(
        .KEY_COUNT (KEY_COUNT)
    ) u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (c_load),
        .take       (take),
        .rem        (rem_c),
        .grp_in     (grp_c),
        .valid      (m_tvalid),
        .key        (o_key),
        .kind       (o_kind),
        .wait_ticks (o_wait),
        .last       (m_tlast)
    );

    assign m_tdata = {7'd0, o_wait, o_key};
    assign m_tuser = o_kind;

    `KPGD_ASSERT_NEXT(a_acc_fills, s_tvalid && s_tready, a_v_reg, "accepted word not in input stage")
    `KPGD_ASSERT_NEXT(b_stall_holds, b_v_reg && !b_adv, b_v_reg, "stalled state stage lost its word")
    `KPGD_ASSERT_NEXT(grp_continues, m_tvalid && m_tready && !m_tlast, m_tvalid, "result group cut short")
    `KPGD_ASSERT_NEXT(grp_drains, m_tvalid && m_tready && m_tlast && !c_v_reg, !m_tvalid, "output valid with nothing loaded")

endmodule
